// File: rtl/lbpc_pkg.sv
package lbpc_pkg;

  localparam int NUM_LEDS_DEF  = 4;
  localparam int PIN_W         = 4;
  localparam int SEL_W         = 2;
  localparam int TOTAL_W       = 4;
  localparam int PHASE_W       = 3;
  localparam logic [PHASE_W-1:0] PHASE_LAST = 3'd5;
  localparam logic [PHASE_W-1:0] PHASE_SLOW_EDGE = 3'd2;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_SET   = 2'd1,
    KIND_BLINK = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_ON   = 2'd1,
    MODE_SLOW = 2'd2,
    MODE_FAST = 2'd3
  } mode_t;

  // Command broadcast to every lane for the item being retired
  typedef struct packed {
    logic                 go;
    logic                 tick;
    logic                 set;
    logic                 blink_ok;
    logic [SEL_W-1:0]     sel;
    mode_t                mode;
    logic [TOTAL_W-1:0]   total;
    logic                 rep;
    logic [PHASE_W-1:0]   phase_cur;
    logic [PHASE_W-1:0]   phase_nxt;
  } lane_cmd_t;

  // Status returned by each lane
  typedef struct packed {
    logic busy_first;
    logic pin_nxt;
  } lane_stat_t;

  // Steady level of a mode at a given phase
  function automatic logic mode_level(mode_t m, logic [PHASE_W-1:0] ph);
    logic lvl;
    case (m)
      MODE_ON:   lvl = 1'b1;
      MODE_SLOW: lvl = (ph > PHASE_SLOW_EDGE);
      MODE_FAST: lvl = ph[0];
      default:   lvl = 1'b0;
    endcase
    return lvl;
  endfunction

endpackage

// File: rtl/lbpc_if.sv
interface lbpc_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    kind;
  logic [lbpc_pkg::SEL_W-1:0]    led_select;
  logic [1:0]                    mode;
  logic [lbpc_pkg::TOTAL_W-1:0]  pulse_total;
  logic                          repeat_burst;

  modport source (output valid, kind, led_select, mode, pulse_total, repeat_burst,
                  input ready);
  modport sink   (input valid, kind, led_select, mode, pulse_total, repeat_burst,
                  output ready);
endinterface

interface lbpc_out_if;
  logic                          valid;
  logic                          ready;
  logic [lbpc_pkg::PIN_W-1:0]    led_pins;
  logic                          accepted;

  modport source (output valid, led_pins, accepted, input ready);
  modport sink   (input valid, led_pins, accepted, output ready);
endinterface

// File: rtl/led_blink_pattern_controller_core.sv
// Channel | dir | payload                                          | transfer
// in_ch   | in  | kind, led_select, mode, pulse_total, repeat_burst | valid & ready
// out_ch  | out | led_pins, accepted                               | valid & ready
//
// One item per cycle sustained while out_ch.ready holds; the result passes the input
// register, then all lanes update into the result register.
// The result register lets a new item enter while a finished result waits.
// rst_n is synchronous: phase zero, all modes off, no bursts, pins dark.
// A stalled result holds the input register; in_ch.ready drops only then.
module led_blink_pattern_controller_core #(
  parameter int NUM_LEDS = lbpc_pkg::NUM_LEDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  lbpc_in_if.sink     in_ch,
  lbpc_out_if.source  out_ch
);

  localparam int PIN_W = lbpc_pkg::PIN_W;

  // Input register
  logic                          stage_valid_r, stage_valid_nxt;
  lbpc_pkg::kind_t               kind_r;
  logic [lbpc_pkg::SEL_W-1:0]    sel_r;
  lbpc_pkg::mode_t               mode_r;
  logic [lbpc_pkg::TOTAL_W-1:0]  total_r;
  logic                          rep_r;

  // Result register
  logic                          out_valid_r, out_valid_nxt;
  logic [PIN_W-1:0]              led_pins_r;
  logic                          accepted_r;

  logic                          in_xfer;
  logic                          go;
  logic                          is_tick, is_set, is_blink;
  logic                          blink_ok;
  logic [lbpc_pkg::PHASE_W-1:0]  phase_cur, phase_nxt;
  lbpc_pkg::lane_cmd_t           cmd;
  lbpc_pkg::lane_stat_t          stat [NUM_LEDS];
  logic [NUM_LEDS-1:0]           busy_vec;
  logic [NUM_LEDS-1:0]           pin_vec;
  logic [NUM_LEDS+PIN_W-1:0]     busy_ext, pin_ext, have_ext;
  logic [PIN_W-1:0]              busy4, pin4, have4;

  assign go      = stage_valid_r && (!out_valid_r || out_ch.ready);
  assign in_xfer = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !stage_valid_r || go;

  // Hold the item until the result side can take it
  always_comb begin
    stage_valid_nxt = stage_valid_r;
    if (in_xfer) begin
      stage_valid_nxt = 1'b1;
    end else if (go) begin
      stage_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      kind_r  <= lbpc_pkg::kind_t'(in_ch.kind);
      sel_r   <= in_ch.led_select;
      mode_r  <= lbpc_pkg::mode_t'(in_ch.mode);
      total_r <= in_ch.pulse_total;
      rep_r   <= in_ch.repeat_burst;
    end
  end

  // Decode the item kind
  always_comb begin
    is_tick  = 1'b0;
    is_set   = 1'b0;
    is_blink = 1'b0;
    case (kind_r)
      lbpc_pkg::KIND_TICK:  is_tick  = 1'b1;
      lbpc_pkg::KIND_SET:   is_set   = 1'b1;
      lbpc_pkg::KIND_BLINK: is_blink = 1'b1;
      default: ;
    endcase
  end

  lbpc_phase u_phase (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (go && is_tick),
    .phase_cur (phase_cur),
    .phase_nxt (phase_nxt)
  );

  // Gather lane status, padded so the low four LEDs are always addressable
  always_comb begin
    for (int i = 0; i < NUM_LEDS; i++) begin
      busy_vec[i] = stat[i].busy_first;
      pin_vec[i]  = stat[i].pin_nxt;
    end
  end

  assign busy_ext = {{PIN_W{1'b0}}, busy_vec};
  assign pin_ext  = {{PIN_W{1'b0}}, pin_vec};
  assign have_ext = {{PIN_W{1'b0}}, {NUM_LEDS{1'b1}}};
  assign busy4    = busy_ext[PIN_W-1:0];
  assign pin4     = pin_ext[PIN_W-1:0];
  assign have4    = have_ext[PIN_W-1:0];

  // Refuse a blink for a missing LED or one still in its first pass
  assign blink_ok = is_blink && have4[sel_r] && !busy4[sel_r];

  always_comb begin
    cmd           = '0;
    cmd.go        = go;
    cmd.tick      = is_tick;
    cmd.set       = is_set;
    cmd.blink_ok  = blink_ok;
    cmd.sel       = sel_r;
    cmd.mode      = mode_r;
    cmd.total     = total_r;
    cmd.rep       = rep_r;
    cmd.phase_cur = phase_cur;
    cmd.phase_nxt = phase_nxt;
  end

  for (genvar g = 0; g < NUM_LEDS; g++) begin : g_lane
    lbpc_lane #(.IDX(g)) u_lane (
      .clk  (clk),
      .rst_n(rst_n),
      .cmd  (cmd),
      .stat (stat[g])
    );
  end

  // Load a result on each retired item, drop it once transferred
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      led_pins_r <= pin4;
      accepted_r <= blink_ok || !is_blink;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.led_pins = led_pins_r;
  assign out_ch.accepted = accepted_r;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> stage_valid_r && out_valid_r)
    else $error("input stalled with room to spare");

  a_retire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> out_valid_r)
    else $error("retired item produced no result");

  a_refusal_only_blink: assert property (@(posedge clk) disable iff (!rst_n)
    go && !is_blink |=> accepted_r)
    else $error("non-blink item refused");

endmodule

// File: rtl/lbpc_phase.sv
module lbpc_phase (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  output logic [lbpc_pkg::PHASE_W-1:0]   phase_cur,
  output logic [lbpc_pkg::PHASE_W-1:0]   phase_nxt
);

  logic [lbpc_pkg::PHASE_W-1:0] phase_r;

  // Advance on a tick, wrap after the last phase
  always_comb begin
    phase_nxt = phase_r;
    if (adv) begin
      if (phase_r >= lbpc_pkg::PHASE_LAST) begin
        phase_nxt = '0;
      end else begin
        phase_nxt = phase_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  assign phase_cur = phase_r;

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= lbpc_pkg::PHASE_LAST)
    else $error("phase left its range");

  a_phase_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    adv && phase_r == lbpc_pkg::PHASE_LAST |=> phase_r == '0)
    else $error("phase did not wrap");

endmodule

// File: rtl/lbpc_lane.sv
module lbpc_lane #(
  parameter int IDX = 0
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  lbpc_pkg::lane_cmd_t     cmd,
  output lbpc_pkg::lane_stat_t    stat
);

  lbpc_pkg::mode_t              mode_r,  mode_nxt;
  logic [lbpc_pkg::TOTAL_W-1:0] len_r,   len_nxt;
  logic [lbpc_pkg::TOTAL_W-1:0] pos_r,   pos_nxt;
  logic                         rep_r,   rep_nxt;
  logic                         first_r, first_nxt;
  logic                         pin_r,   pin_nxt;
  logic                         hit;

  assign hit = (int'(cmd.sel) == IDX);

  // Burst step on a tick, mode write on set, burst load on an accepted blink
  always_comb begin
    mode_nxt  = mode_r;
    len_nxt   = len_r;
    pos_nxt   = pos_r;
    rep_nxt   = rep_r;
    first_nxt = first_r;
    pin_nxt   = pin_r;
    if (cmd.go) begin
      if (cmd.tick && len_r != '0) begin
        if (cmd.phase_nxt[0]) begin
          if (pos_r < len_r) begin
            pin_nxt = 1'b1;
            pos_nxt = pos_r + 4'd1;
          end else begin
            pos_nxt   = '0;
            first_nxt = 1'b0;
            if (!rep_r) begin
              len_nxt = '0;
            end
          end
        end else begin
          pin_nxt = 1'b0;
        end
      end
      if (cmd.set && hit) begin
        rep_nxt  = 1'b0;
        mode_nxt = cmd.mode;
      end
      if (cmd.blink_ok && hit) begin
        pos_nxt   = '0;
        len_nxt   = cmd.total;
        first_nxt = 1'b1;
        rep_nxt   = cmd.rep;
      end
      // No burst: pin shows the mode at the new phase
      if (len_nxt == '0) begin
        pin_nxt = lbpc_pkg::mode_level(mode_nxt, cmd.phase_nxt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= lbpc_pkg::MODE_OFF;
      len_r   <= '0;
      pos_r   <= '0;
      rep_r   <= 1'b0;
      first_r <= 1'b0;
      pin_r   <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      len_r   <= len_nxt;
      pos_r   <= pos_nxt;
      rep_r   <= rep_nxt;
      first_r <= first_nxt;
      pin_r   <= pin_nxt;
    end
  end

  assign stat.busy_first = (len_r != '0) && first_r;
  assign stat.pin_nxt    = pin_nxt;

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= len_r)
    else $error("burst position past burst length");

  a_idle_follows_mode: assert property (@(posedge clk) disable iff (!rst_n)
    len_r == '0 |-> pin_r == lbpc_pkg::mode_level(mode_r, cmd.phase_cur))
    else $error("idle pin does not follow its mode");

  a_refused_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.go && cmd.blink_ok && hit |=> first_r && len_r == $past(cmd.total))
    else $error("accepted blink not loaded");

endmodule

// File: tb/tb_led_blink_pattern_controller_core.sv
`timescale 1ns / 1ps

module tb_led_blink_pattern_controller_core;

  localparam int NUM_LEDS = lbpc_pkg::NUM_LEDS_DEF;
  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam int SCRIPT_LEN = 22;
  localparam int ITEM_TARGET = 1900;
  localparam int PRESSURE_CYCLES = 400;

  typedef logic [lbpc_pkg::SEL_W-1:0]   sel_t;
  typedef logic [lbpc_pkg::TOTAL_W-1:0] total_t;

  typedef struct packed {
    logic [1:0]      kind;
    sel_t            sel;
    lbpc_pkg::mode_t mode;
    total_t          total;
    logic            rep;
  } led_req_t;

  typedef struct packed {
    logic [lbpc_pkg::PIN_W-1:0] pins;
    logic                       acc;
  } led_view_t;

  typedef struct {
    led_req_t                   rq;
    bit                         pins_known;
    logic [lbpc_pkg::PIN_W-1:0] pins;
    bit                         acc_known;
    logic                       acc;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n;

  lbpc_in_if  in_ch ();
  lbpc_out_if out_ch ();

  led_blink_pattern_controller_core #(.NUM_LEDS(NUM_LEDS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted LED state
  logic [lbpc_pkg::PHASE_W-1:0] ph;
  lbpc_pkg::mode_t              led_mode    [NUM_LEDS];
  total_t                       burst_len   [NUM_LEDS];
  total_t                       burst_pos   [NUM_LEDS];
  logic                         burst_rep   [NUM_LEDS];
  logic                         burst_first [NUM_LEDS];
  logic                         lamp        [NUM_LEDS];

  led_view_t lamp_due [$];

  int mismatches = 0;
  int n_checked = 0;
  int n_ticks = 0;
  int n_sets = 0;
  int n_spare = 0;
  int n_taken = 0;
  int n_refused = 0;
  int driven = 0;

  bit sender_idles = 1'b1;
  logic pressure_req = 1'b0;
  bit pressure_seen = 1'b0;
  int stall_left = 0;
  int rx_cycles = 0;

  // Directed script: typed values only where obvious, the rest predicted
  script_row_t script [SCRIPT_LEN] = '{
    '{'{lbpc_pkg::KIND_TICK, 2'd0, lbpc_pkg::MODE_OFF, 4'd0, 1'b0}, 1'b1, 4'b0000, 1'b1, 1'b1},
    '{'{lbpc_pkg::KIND_SET, 2'd0, lbpc_pkg::MODE_ON, 4'd0, 1'b0}, 1'b1, 4'b0001, 1'b1, 1'b1},
    '{'{lbpc_pkg::KIND_SET, 2'd1, lbpc_pkg::MODE_SLOW, 4'd0, 1'b0}, 1'b0, 4'b0000, 1'b0, 1'b0},
    '{'{lbpc_pkg::KIND_SET, 2'd2, lbpc_pkg::MODE_FAST, 4'd0, 1'b0}, 1'b0, 4'b0000, 1'b0, 1'b0},
    '{'{lbpc_pkg::KIND_SET, 2'd3, lbpc_pkg::MODE_ON, 4'd0, 1'b0}, 1'b0, 4'b0000, 1'b0, 1'b0},
    '{'{lbpc_pkg::KIND_BLINK, 2'd3, lbpc_pkg::MODE_OFF, 4'd2, 1'b0}, 1'b0, 4'b0000, 1'b1, 1'b1},
    '{'{lbpc_pkg::KIND_BLINK, 2'd3, lbpc_pkg::MODE_OFF, 4'd5, 1'b1}, 1'b0, 4'b0000, 1'b1, 1'b0},
    '{'{lbpc_pkg::KIND_TICK, 2'd0, lbpc_pkg::MODE_OFF, 4'd0, 1'b0}, 1'b0, 4'b0000, 1'b0, 1'b0},
    '{'{lbpc_pkg::KIND_TICK, 2'd1, lbpc_pkg::MODE_ON, 4'd3, 1'b1}, 1'b0, 4'b0000, 1'b0, 1'b0},
    '{'{lbpc_pkg::KIND_TICK, 2'd2, lbpc_pkg::MODE_SLOW, 4'd7, 1'b0}, 1'b0, 4'b0000, 1'b0, 1'b0},
    '{'{lbpc_pkg::KIND_TICK, 2'd3, lbpc_pkg::MODE_FAST, 4'd15, 1'b1}, 1'b0, 4'b0000, 1'b0, 1'b0},
    '{'{lbpc_pkg::KIND_TICK, 2'd0, lbpc_pkg::MODE_OFF, 4'd0, 1'b0}, 1'b0, 4'b0000, 1'b0, 1'b0},
    '{'{lbpc_pkg::KIND_TICK, 2'd0, lbpc_pkg::MODE_OFF, 4'd0, 1'b0}, 1'b0, 4'b0000, 1'b0, 1'b0},
    '{'{lbpc_pkg::KIND_BLINK, 2'd0, lbpc_pkg::MODE_OFF, 4'd15, 1'b1}, 1'b0, 4'b0000, 1'b1, 1'b1},
    '{'{lbpc_pkg::KIND_TICK, 2'd0, lbpc_pkg::MODE_OFF, 4'd0, 1'b0}, 1'b0, 4'b0000, 1'b0, 1'b0},
    '{'{lbpc_pkg::KIND_TICK, 2'd0, lbpc_pkg::MODE_OFF, 4'd0, 1'b0}, 1'b0, 4'b0000, 1'b0, 1'b0},
    '{'{lbpc_pkg::KIND_SET, 2'd0, lbpc_pkg::MODE_FAST, 4'd0, 1'b0}, 1'b0, 4'b0000, 1'b0, 1'b0},
    '{'{lbpc_pkg::KIND_BLINK, 2'd1, lbpc_pkg::MODE_ON, 4'd0, 1'b1}, 1'b0, 4'b0000, 1'b1, 1'b1},
    '{'{lbpc_pkg::KIND_BLINK, 2'd2, lbpc_pkg::MODE_OFF, 4'd1, 1'b1}, 1'b0, 4'b0000, 1'b1, 1'b1},
    '{'{KIND_SPARE, 2'd3, lbpc_pkg::MODE_FAST, 4'd15, 1'b1}, 1'b0, 4'b0000, 1'b1, 1'b1},
    '{'{lbpc_pkg::KIND_BLINK, 2'd2, lbpc_pkg::MODE_OFF, 4'd9, 1'b0}, 1'b0, 4'b0000, 1'b1, 1'b0},
    '{'{lbpc_pkg::KIND_TICK, 2'd0, lbpc_pkg::MODE_OFF, 4'd0, 1'b0}, 1'b0, 4'b0000, 1'b0, 1'b0}
  };

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Advance the LED state by one item and return the pins it leaves
  function automatic led_view_t step_leds(led_req_t rq);
    led_view_t v;
    v.acc = 1'b1;
    v.pins = '0;
    case (rq.kind)
      lbpc_pkg::KIND_TICK: begin
        n_ticks++;
        ph = (ph >= lbpc_pkg::PHASE_LAST) ? '0 : ph + 1'b1;
        for (int i = 0; i < NUM_LEDS; i++) begin
          if (burst_len[i] != 0) begin
            if (ph[0]) begin
              if (burst_pos[i] < burst_len[i]) begin
                lamp[i] = 1'b1;
                burst_pos[i] = burst_pos[i] + 1'b1;
              end else begin
                // End of a pass: restart only when repeating
                burst_pos[i] = '0;
                burst_first[i] = 1'b0;
                if (!burst_rep[i]) burst_len[i] = '0;
              end
            end else begin
              lamp[i] = 1'b0;
            end
          end
        end
      end
      lbpc_pkg::KIND_SET: begin
        n_sets++;
        burst_rep[rq.sel] = 1'b0;
        led_mode[rq.sel] = rq.mode;
      end
      lbpc_pkg::KIND_BLINK: begin
        if (burst_len[rq.sel] != 0 && burst_first[rq.sel]) begin
          v.acc = 1'b0;
          n_refused++;
        end else begin
          burst_pos[rq.sel] = '0;
          burst_len[rq.sel] = rq.total;
          burst_first[rq.sel] = 1'b1;
          burst_rep[rq.sel] = rq.rep;
          n_taken++;
        end
      end
      default: n_spare++;
    endcase
    // Idle LEDs show their mode at the current phase
    for (int i = 0; i < NUM_LEDS; i++) begin
      if (burst_len[i] == 0) begin
        case (led_mode[i])
          lbpc_pkg::MODE_ON:   lamp[i] = 1'b1;
          lbpc_pkg::MODE_SLOW: lamp[i] = (ph > lbpc_pkg::PHASE_SLOW_EDGE);
          lbpc_pkg::MODE_FAST: lamp[i] = ph[0];
          default:             lamp[i] = 1'b0;
        endcase
      end
      if (i < lbpc_pkg::PIN_W) v.pins[i] = lamp[i];
    end
    return v;
  endfunction

  function automatic led_req_t random_req();
    led_req_t rq;
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) rq.kind = lbpc_pkg::KIND_TICK;
    else if (r < 65) rq.kind = lbpc_pkg::KIND_SET;
    else if (r < 90) rq.kind = lbpc_pkg::KIND_BLINK;
    else rq.kind = KIND_SPARE;
    rq.sel = sel_t'($urandom_range(0, NUM_LEDS - 1));
    rq.mode = lbpc_pkg::mode_t'($urandom_range(0, 3));
    rq.total = total_t'($urandom_range(0, 15));
    rq.rep = ($urandom_range(0, 1) != 0);
    return rq;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Offer one item, hold it until transfer, then record its prediction
  task automatic offer(input script_row_t row);
    int gap;
    led_view_t v;
    gap = sender_idles ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.kind         <= row.rq.kind;
    in_ch.led_select   <= row.rq.sel;
    in_ch.mode         <= row.rq.mode;
    in_ch.pulse_total  <= row.rq.total;
    in_ch.repeat_burst <= row.rq.rep;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    v = step_leds(row.rq);
    if (row.pins_known) v.pins = row.pins;
    if (row.acc_known) v.acc = row.acc;
    lamp_due.push_back(v);
    driven++;
  endtask

  task automatic offer_random(input led_req_t rq);
    script_row_t row;
    row.rq = rq;
    row.pins_known = 1'b0;
    row.pins = '0;
    row.acc_known = 1'b0;
    row.acc = 1'b0;
    offer(row);
  endtask

  task automatic check_result(input logic [lbpc_pkg::PIN_W-1:0] pins, input logic acc);
    led_view_t want;
    if (lamp_due.size() == 0) begin
      flag_mismatch($sformatf("result pins=%b accepted=%b with nothing outstanding",
                              pins, acc));
    end else begin
      want = lamp_due.pop_front();
      n_checked++;
      if (pins !== want.pins)
        flag_mismatch($sformatf("led_pins %b, want %b", pins, want.pins));
      if (acc !== want.acc)
        flag_mismatch($sformatf("accepted %b, want %b", acc, want.acc));
    end
  endtask

  // Result side: check each transfer, then pick the next ready level
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      check_result(out_ch.led_pins, out_ch.accepted);
    rx_cycles <= rx_cycles + 1;
    if (rst_n !== 1'b1) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (pressure_req && !pressure_seen) begin
      // Long hold-off so the block fills and stalls its input
      pressure_seen <= 1'b1;
      stall_left <= PRESSURE_CYCLES;
      out_ch.ready <= 1'b0;
    end else if ((rx_cycles % 4096) < 1024 || $urandom_range(0, 3) != 0) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= 1'b0;
      stall_left <= pick_gap();
    end
  end

  // Stimulus
  initial begin
    led_req_t rq;
    int run_len;
    in_ch.valid = 1'b0;
    in_ch.kind = lbpc_pkg::KIND_TICK;
    in_ch.led_select = '0;
    in_ch.mode = '0;
    in_ch.pulse_total = '0;
    in_ch.repeat_burst = 1'b0;
    out_ch.ready = 1'b0;
    rst_n = 1'b0;
    ph = '0;
    for (int i = 0; i < NUM_LEDS; i++) begin
      led_mode[i] = lbpc_pkg::MODE_OFF;
      burst_len[i] = '0;
      burst_pos[i] = '0;
      burst_rep[i] = 1'b0;
      burst_first[i] = 1'b0;
      lamp[i] = 1'b0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed walk
    foreach (script[k]) offer(script[k]);

    // Random: mostly bursts followed by ticks, the rest loose items
    while (driven < ITEM_TARGET) begin
      sender_idles = ((driven / 150) % 3) != 0;
      if (driven > 600 && !pressure_req) begin
        pressure_req <= 1'b1;
        sender_idles = 1'b0;
        repeat (60) offer_random(random_req());
      end else if ($urandom_range(0, 3) == 0) begin
        rq = random_req();
        rq.kind = lbpc_pkg::KIND_BLINK;
        offer_random(rq);
        run_len = $urandom_range(2, 2 * rq.total + 4);
        repeat (run_len) begin
          rq = random_req();
          if ($urandom_range(0, 9) != 0) rq.kind = lbpc_pkg::KIND_TICK;
          offer_random(rq);
        end
      end else begin
        offer_random(random_req());
      end
    end
    in_ch.valid <= 1'b0;

    // Drain outstanding results, then let the pipeline settle
    while (lamp_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Run covered %0d ticks, %0d mode sets, %0d blinks taken, %0d refused,",
             n_ticks, n_sets, n_taken, n_refused);
    $display("%0d spare-kind items and %0d checked results.", n_spare, n_checked);
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("Timeout with %0d results outstanding", lamp_due.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
